// ===== rtl/core/breakpoint_envelope_table_unit_defines.svh =====
// Assertion macros for the breakpoint envelope table unit.
// Used by the top level only; depends on nothing else.
`ifndef BREAKPOINT_ENVELOPE_TABLE_UNIT_DEFINES_SVH
`define BREAKPOINT_ENVELOPE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BET_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define BET_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/bet_pkg.sv =====
// Shared widths, codes and types of the breakpoint envelope table unit.
// No dependencies; imported by the interfaces, the divider and the top level.
package bet_pkg;

  localparam int TIME_W = 24;
  localparam int VAL_W  = 16;
  localparam int CMD_W  = 3;
  localparam int CHF_W  = 5;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;

  localparam int DEF_NUM_CHANNELS = 32;
  localparam int DEF_MAX_POINTS   = 16;
  localparam logic [TIME_W-1:0] TOTAL_RESET = '1;

  localparam logic [CMD_W-1:0] CMD_SET    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GETALL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;

  // Product of a time difference and a value difference, signed.
  localparam int PROD_W = TIME_W + VAL_W + 2;
  localparam int MAG_W  = PROD_W - 1;
  localparam int QUO_W  = VAL_W + 1;

  typedef struct packed {
    logic [TIME_W-1:0]       t;
    logic signed [VAL_W-1:0] v;
  } point_t;

  typedef struct packed {
    logic                     start;
    logic signed [PROD_W-1:0] dividend;
    logic [TIME_W-1:0]        divisor;
  } div_req_t;

endpackage

// ===== rtl/core/bet_ifs.sv =====
// Request and response channel interfaces of the envelope table unit.
// Depends on bet_pkg for field widths.
interface bet_req_if;
  import bet_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [CHF_W-1:0]        channel;
  logic [TIME_W-1:0]       time_req;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;
  modport source (output valid, cmd, channel, time_req, value, position, input ready);
  modport sink (input valid, cmd, channel, time_req, value, position, output ready);
endinterface

interface bet_rsp_if;
  import bet_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;
  logic [CHF_W-1:0]        result_channel;
  logic [STAT_W-1:0]       status;
  logic                    last;
  modport source (output valid, result_value, result_channel, status, last, input ready);
  modport sink (input valid, result_value, result_channel, status, last, output ready);
endinterface

// ===== rtl/core/bet_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
module bet_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 512
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/bet_div.sv =====
// Restoring divider, one quotient bit per cycle, signed dividend.
// Depends on bet_pkg for widths and the request struct.
module bet_div (
  input  logic                            clk,
  input  logic                            rst,
  input  bet_pkg::div_req_t               req,
  output logic                            done,
  output logic signed [bet_pkg::QUO_W-1:0] quo
);
  import bet_pkg::*;
  localparam int CW = $clog2(MAG_W + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [TIME_W:0]   rem;
  logic [MAG_W-1:0]  q;
  logic [TIME_W-1:0] den;
  logic              neg;
  logic [PROD_W-1:0] mag_c;
  logic [TIME_W:0]   rem_sh;
  logic              fits;

  assign mag_c  = req.dividend[PROD_W-1] ? PROD_W'(-req.dividend) : PROD_W'(req.dividend);
  assign rem_sh = {rem[TIME_W-1:0], q[MAG_W-1]};
  assign fits   = rem_sh >= {1'b0, den};
  assign quo    = neg ? -$signed(q[QUO_W-1:0]) : $signed(q[QUO_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(MAG_W);
        q    <= mag_c[MAG_W-1:0];
        rem  <= '0;
        den  <= req.divisor;
        neg  <= req.dividend[PROD_W-1];
      end else if (busy) begin
        rem <= fits ? rem_sh - {1'b0, den} : rem_sh;
        q   <= {q[MAG_W-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/breakpoint_envelope_table_unit.sv =====
// Breakpoint envelope table: per-channel sorted breakpoint lists in one RAM,
// a read-modify-write sequencer, and a bit-serial divider for interpolation.
// Depends on bet_pkg, bet_ifs, bet_ram, bet_div and the defines header.
//
// One item is processed at a time. After reset the unit writes the initial
// two points of every list and holds ready low meanwhile. A get walks the
// list point by point and, when the time falls between points, runs the
// multiply and the 41-step divide; a set walks the list and, unless the time
// already exists, shifts the later points up, and a remove shifts the later
// points down, each step bound by the single RAM read port; get-all repeats
// the get sequence for every channel and emits one item per channel. Config
// writes take effect on later clears, get clamping and sets past the total
// time only.
`include "breakpoint_envelope_table_unit_defines.svh"
module breakpoint_envelope_table_unit #(
  parameter int NUM_CHANNELS = bet_pkg::DEF_NUM_CHANNELS,
  parameter int MAX_POINTS   = bet_pkg::DEF_MAX_POINTS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bet_pkg::TIME_W-1:0] cfg_wdata,
  bet_req_if.sink                    req,
  bet_rsp_if.source                  rsp
);
  import bet_pkg::*;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CHX_W  = (CH_W > CHF_W) ? CH_W : CHF_W;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int DEPTH  = NUM_CHANNELS * MAX_POINTS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW     = $bits(point_t);

  localparam logic [4:0] S_INIT     = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_DISP     = 5'd2;
  localparam logic [4:0] S_CLR2     = 5'd3;
  localparam logic [4:0] S_SCAN_RD  = 5'd4;
  localparam logic [4:0] S_SCAN_WT  = 5'd5;
  localparam logic [4:0] S_SH_UP_RD = 5'd6;
  localparam logic [4:0] S_SH_UP_WR = 5'd7;
  localparam logic [4:0] S_SH_DN_RD = 5'd8;
  localparam logic [4:0] S_SH_DN_WR = 5'd9;
  localparam logic [4:0] S_RMZ      = 5'd10;
  localparam logic [4:0] S_MUL      = 5'd11;
  localparam logic [4:0] S_DIVGO    = 5'd12;
  localparam logic [4:0] S_DIVWT    = 5'd13;
  localparam logic [4:0] S_EMIT     = 5'd14;

  logic [4:0]              state;
  logic [TIME_W-1:0]       total_time;
  logic [CMD_W-1:0]        cur_cmd;
  logic [CH_W-1:0]         cur_ch;
  logic [CHF_W-1:0]        ch_field;
  logic [TIME_W-1:0]       cur_t;
  logic signed [VAL_W-1:0] cur_v;
  logic [POS_W-1:0]        cur_pos;
  logic [CNT_W-1:0]        i;
  logic [CNT_W-1:0]        k;
  point_t                  prev;
  point_t                  curp;
  logic signed [VAL_W-1:0] res_val;
  logic [STAT_W-1:0]       res_stat;
  logic signed [PROD_W-1:0] prod;
  logic [TIME_W-1:0]       den;
  logic [CH_W-1:0]         init_ch;
  logic                    init_ph;
  logic [CNT_W-1:0]        counts [NUM_CHANNELS];

  logic                    out_valid;
  logic signed [VAL_W-1:0] out_val;
  logic [CHF_W-1:0]        out_ch;
  logic [STAT_W-1:0]       out_st;
  logic                    out_last;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [ADDR_W-1:0]       ram_raddr;
  point_t                  ram_wdata;
  point_t                  rdata;
  logic [PW-1:0]           rdata_raw;

  div_req_t                div_req;
  logic                    div_done;
  logic signed [QUO_W-1:0] div_quo;

  logic [CNT_W-1:0]        n;
  logic [CHX_W-1:0]        ch_ext;
  logic [CMP_W-1:0]        pos_x;
  logic [CMP_W-1:0]        n_x;
  logic [CNT_W-1:0]        pos_idx;
  logic                    pos_bad;
  logic                    pos_end;
  logic                    is_set;
  logic                    full;
  logic signed [TIME_W:0]  dt_s;
  logic signed [VAL_W:0]   dv_s;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [VAL_W:0]   sum_c;
  logic                    emit_go;
  logic                    emit_last;

  function automatic logic [ADDR_W-1:0] pt_addr(input logic [CH_W-1:0] ch,
                                                input logic [CNT_W-1:0] idx);
    pt_addr = ADDR_W'(int'(ch) * MAX_POINTS + int'(idx));
  endfunction

  assign n         = counts[cur_ch];
  assign ch_ext    = CHX_W'(req.channel);
  assign pos_x     = CMP_W'(cur_pos);
  assign n_x       = CMP_W'(n);
  assign pos_idx   = CNT_W'(cur_pos - POS_W'(1));
  assign pos_bad   = (cur_pos == '0) || (pos_x > n_x);
  assign pos_end   = (cur_pos == POS_W'(1)) || (pos_x == n_x);
  assign is_set    = cur_cmd == CMD_SET;
  assign full      = int'(n) >= MAX_POINTS;
  assign dt_s      = {1'b0, cur_t - prev.t};
  assign dv_s      = {curp.v[VAL_W-1], curp.v} - {prev.v[VAL_W-1], prev.v};
  assign prod_c    = dt_s * dv_s;
  assign sum_c     = {prev.v[VAL_W-1], prev.v} + div_quo;
  assign emit_go   = !out_valid || rsp.ready;
  assign emit_last = (cur_cmd != CMD_GETALL) || (cur_ch == CH_W'(NUM_CHANNELS - 1));
  assign rdata     = point_t'(rdata_raw);

  assign req.ready          = state == S_IDLE;
  assign rsp.valid          = out_valid;
  assign rsp.result_value   = out_val;
  assign rsp.result_channel = out_ch;
  assign rsp.status         = out_st;
  assign rsp.last           = out_last;

  assign div_req.start    = state == S_DIVGO;
  assign div_req.dividend = prod;
  assign div_req.divisor  = den;

  // RAM access for the current sequencer step.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pt_addr(cur_ch, i);
    ram_wdata = '{t: cur_t, v: cur_v};
    ram_raddr = pt_addr(cur_ch, i);
    unique case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = pt_addr(init_ch, CNT_W'(init_ph));
        ram_wdata = '{t: init_ph ? TOTAL_RESET : '0, v: '0};
      end
      S_DISP: begin
        if (is_set && cur_t > total_time) begin
          ram_we    = 1'b1;
          ram_waddr = pt_addr(cur_ch, n - CNT_W'(1));
          ram_wdata = '{t: total_time, v: cur_v};
        end else if (cur_cmd == CMD_CLEAR) begin
          ram_we    = 1'b1;
          ram_waddr = pt_addr(cur_ch, '0);
          ram_wdata = '{t: '0, v: '0};
        end
        ram_raddr = pt_addr(cur_ch, pos_idx);
      end
      S_CLR2: begin
        ram_we    = 1'b1;
        ram_waddr = pt_addr(cur_ch, CNT_W'(1));
        ram_wdata = '{t: total_time, v: '0};
      end
      S_SCAN_WT: begin
        ram_we = is_set && (rdata.t == cur_t);
      end
      S_SH_UP_RD: begin
        ram_we    = k == i;
        ram_raddr = pt_addr(cur_ch, k - CNT_W'(1));
      end
      S_SH_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pt_addr(cur_ch, k);
        ram_wdata = rdata;
      end
      S_SH_DN_RD: begin
        ram_raddr = pt_addr(cur_ch, k + CNT_W'(1));
      end
      S_SH_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pt_addr(cur_ch, k);
        ram_wdata = rdata;
      end
      S_RMZ: begin
        ram_we    = 1'b1;
        ram_waddr = pt_addr(cur_ch, pos_idx);
        ram_wdata = '{t: rdata.t, v: '0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_time <= TOTAL_RESET;
    end else if (cfg_we) begin
      total_time <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_ch   <= '0;
      init_ph   <= 1'b0;
      out_valid <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        counts[c] <= CNT_W'(2);
      end
    end else begin
      unique case (state)
        S_INIT: begin
          init_ph <= !init_ph;
          if (init_ph) begin
            if (init_ch == CH_W'(NUM_CHANNELS - 1)) begin
              state <= S_IDLE;
            end else begin
              init_ch <= init_ch + CH_W'(1);
            end
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            cur_cmd  <= req.cmd;
            ch_field <= req.channel;
            cur_t    <= req.time_req;
            cur_v    <= req.value;
            cur_pos  <= req.position;
            res_val  <= '0;
            res_stat <= ST_OK;
            if (req.cmd == CMD_GETALL) begin
              cur_ch <= '0;
              state  <= S_DISP;
            end else if (req.cmd > CMD_CLEAR) begin
              state <= S_EMIT;
            end else if (int'(ch_ext) >= NUM_CHANNELS) begin
              res_stat <= ST_BADPOS;
              state    <= S_EMIT;
            end else begin
              cur_ch <= ch_ext[CH_W-1:0];
              state  <= S_DISP;
            end
          end
        end
        S_DISP: begin
          i <= '0;
          priority if (is_set) begin
            state <= (cur_t > total_time) ? S_EMIT : S_SCAN_RD;
          end else if (cur_cmd == CMD_REMOVE) begin
            if (pos_bad) begin
              res_stat <= ST_BADPOS;
              state    <= S_EMIT;
            end else if (pos_end) begin
              state <= S_RMZ;
            end else begin
              k     <= pos_idx;
              state <= S_SH_DN_RD;
            end
          end else if (cur_cmd == CMD_CLEAR) begin
            state <= S_CLR2;
          end else begin
            // Get and get-all walk the list at the clamped time.
            cur_t <= (cur_t > total_time) ? total_time : cur_t;
            state <= S_SCAN_RD;
          end
        end
        S_CLR2: begin
          counts[cur_ch] <= CNT_W'(2);
          state          <= S_EMIT;
        end
        S_SCAN_RD: begin
          if (i >= n) begin
            if (is_set) begin
              if (full) begin
                res_stat <= ST_FULL;
                state    <= S_EMIT;
              end else begin
                k     <= n;
                state <= S_SH_UP_RD;
              end
            end else begin
              // Past the last point: hold its value.
              res_val <= prev.v;
              state   <= S_EMIT;
            end
          end else begin
            state <= S_SCAN_WT;
          end
        end
        S_SCAN_WT: begin
          curp <= rdata;
          if (rdata.t >= cur_t) begin
            if (is_set) begin
              if (rdata.t == cur_t) begin
                state <= S_EMIT;
              end else if (full) begin
                res_stat <= ST_FULL;
                state    <= S_EMIT;
              end else begin
                k     <= n;
                state <= S_SH_UP_RD;
              end
            end else if (rdata.t == cur_t || i == '0) begin
              res_val <= rdata.v;
              state   <= S_EMIT;
            end else begin
              state <= S_MUL;
            end
          end else begin
            prev  <= rdata;
            i     <= i + CNT_W'(1);
            state <= S_SCAN_RD;
          end
        end
        S_SH_UP_RD: begin
          if (k == i) begin
            counts[cur_ch] <= n + CNT_W'(1);
            state          <= S_EMIT;
          end else begin
            state <= S_SH_UP_WR;
          end
        end
        S_SH_UP_WR: begin
          k     <= k - CNT_W'(1);
          state <= S_SH_UP_RD;
        end
        S_SH_DN_RD: begin
          if (CNT_W'(k + CNT_W'(1)) >= n) begin
            counts[cur_ch] <= n - CNT_W'(1);
            state          <= S_EMIT;
          end else begin
            state <= S_SH_DN_WR;
          end
        end
        S_SH_DN_WR: begin
          k     <= k + CNT_W'(1);
          state <= S_SH_DN_RD;
        end
        S_RMZ: begin
          state <= S_EMIT;
        end
        S_MUL: begin
          prod  <= prod_c;
          den   <= curp.t - prev.t;
          state <= S_DIVGO;
        end
        S_DIVGO: begin
          state <= S_DIVWT;
        end
        S_DIVWT: begin
          if (div_done) begin
            res_val <= sum_c[VAL_W-1:0];
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_val   <= res_val;
            out_ch    <= (cur_cmd == CMD_GETALL) ? CHF_W'(cur_ch) : ch_field;
            out_st    <= res_stat;
            out_last  <= emit_last;
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              cur_ch <= cur_ch + CH_W'(1);
              state  <= S_DISP;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // A new item loads the output register; otherwise it empties when taken.
      if (state == S_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  bet_ram #(
    .WIDTH(PW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata_raw)
  );

  bet_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  `BET_ASSERT_NEXT(a_one_item, clk, rst, req.valid && req.ready, !req.ready)
  `BET_ASSERT_NOW(a_count_range, clk, rst, state == S_DISP, int'(n) >= 2 && int'(n) <= MAX_POINTS)
  `BET_ASSERT_NOW(a_div_owner, clk, rst, div_done, state == S_DIVWT)

endmodule
